// ===== hw/rtl/iirdf_pkg.sv =====
// Shared types, constants and the microcode table of the direct form II IIR filter.
package iirdf_pkg;

   // Field and datapath widths.
   localparam int SAMPLE_W   = 16;
   localparam int OUT_W      = 24;
   localparam int COEF_W     = 32;
   localparam int TAP_W      = 48;
   localparam int FRAC_W     = 24;
   localparam int OPND_W     = 25;
   localparam int PROD_W     = COEF_W + OPND_W;
   localparam int ACC_W      = 58;
   localparam int STEP_W     = 5;

   // Configuration port.
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int NUM_REGS   = 5;
   localparam int REG_IDX_W  = 3;

   // Filter order.
   localparam int NUM_COEFS_DEF = 5;
   localparam int MAX_TAPS      = 4;

   // Register indexes.
   localparam logic [REG_IDX_W-1:0] REG_FF_COEF_01  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_FF_COEF_23  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_FB_COEF_01  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_FB_COEF_23  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_COEF_PAIR_4 = 3'd4;

   // Register reset values: unity gain in b0 and a0.
   localparam logic [CSR_DATA_W-1:0] RST_FF_COEF_01  = 64'd16777216;
   localparam logic [CSR_DATA_W-1:0] RST_FF_COEF_23  = 64'd0;
   localparam logic [CSR_DATA_W-1:0] RST_FB_COEF_01  = 64'd16777216;
   localparam logic [CSR_DATA_W-1:0] RST_FB_COEF_23  = 64'd0;
   localparam logic [CSR_DATA_W-1:0] RST_COEF_PAIR_4 = 64'd0;

   // Tap codes of the microword: w0 is the fresh value, w1..w4 the delay line.
   localparam logic [2:0] TAP_W0 = 3'd0;
   localparam logic [2:0] TAP_W1 = 3'd1;
   localparam logic [2:0] TAP_W2 = 3'd2;
   localparam logic [2:0] TAP_W3 = 3'd3;
   localparam logic [2:0] TAP_W4 = 3'd4;

   // Program addresses that are jump targets, and the final step.
   localparam logic [STEP_W-1:0] STEP_FB_DRAIN = 5'd9;
   localparam logic [STEP_W-1:0] STEP_FF_DRAIN = 5'd21;
   localparam logic [STEP_W-1:0] STEP_LAST     = 5'd22;

   // Accumulator operation applied to a registered product.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_LOAD_SHR,
      OP_ADD,
      OP_ADD_SHR,
      OP_SUB,
      OP_SUB_SHR
   } acc_op_type;

   // Coefficient select.
   typedef enum logic [3:0] {
      C_A0, C_A1, C_A2, C_A3, C_A4,
      C_B0, C_B1, C_B2, C_B3, C_B4
   } coef_sel_type;

   // Multiplier operand select: input sample, low or high part of a tap.
   typedef enum logic [1:0] {
      OPND_X,
      OPND_LO,
      OPND_HI
   } opnd_type;

   // Step action on the accumulator result.
   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_SAT_W0,
      ACT_OUT
   } act_type;

   // Sequencer state.
   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   // One control word of the program.
   typedef struct packed {
      coef_sel_type      coef_sel;
      opnd_type          opnd;
      logic [2:0]        tap_sel;
      acc_op_type        op;
      act_type           act;
      logic              jump_en;
      logic [2:0]        jump_below;
      logic [STEP_W-1:0] target;
   } ucode_word_type;

   // Control handed to the multiply-accumulate unit.
   typedef struct packed {
      acc_op_type op;
   } mac_ctrl_type;

   // Builds one control word.
   function automatic ucode_word_type uw(coef_sel_type c, opnd_type o, logic [2:0] t,
                                          acc_op_type p, act_type a, logic j,
                                          logic [2:0] jb, logic [STEP_W-1:0] tg);
      ucode_word_type w;
      w.coef_sel   = c;
      w.opnd       = o;
      w.tap_sel    = t;
      w.op         = p;
      w.act        = a;
      w.jump_en    = j;
      w.jump_below = jb;
      w.target     = tg;
      return w;
   endfunction

   // The program. Each tap term takes two products: coefficient times the low
   // 24 bits (floored by 24) and coefficient times the high part. A jump is
   // taken when NUM_COEFS, the coefficient count, is below jump_below.
   function automatic ucode_word_type ucode_rom(logic [STEP_W-1:0] step);
      ucode_word_type w;
      case (step)
         5'd0:  w = uw(C_A0, OPND_X,  TAP_W0, OP_LOAD,     ACT_NONE,   1'b0, 3'd0, '0);
         5'd1:  w = uw(C_A1, OPND_LO, TAP_W1, OP_SUB_SHR,  ACT_NONE,   1'b0, 3'd0, '0);
         5'd2:  w = uw(C_A1, OPND_HI, TAP_W1, OP_SUB,      ACT_NONE,   1'b0, 3'd0, '0);
         5'd3:  w = uw(C_A2, OPND_LO, TAP_W2, OP_SUB_SHR,  ACT_NONE,   1'b0, 3'd0, '0);
         5'd4:  w = uw(C_A2, OPND_HI, TAP_W2, OP_SUB,      ACT_NONE,   1'b1, 3'd4,
                       STEP_FB_DRAIN);
         5'd5:  w = uw(C_A3, OPND_LO, TAP_W3, OP_SUB_SHR,  ACT_NONE,   1'b0, 3'd0, '0);
         5'd6:  w = uw(C_A3, OPND_HI, TAP_W3, OP_SUB,      ACT_NONE,   1'b1, 3'd5,
                       STEP_FB_DRAIN);
         5'd7:  w = uw(C_A4, OPND_LO, TAP_W4, OP_SUB_SHR,  ACT_NONE,   1'b0, 3'd0, '0);
         5'd8:  w = uw(C_A4, OPND_HI, TAP_W4, OP_SUB,      ACT_NONE,   1'b0, 3'd0, '0);
         5'd9:  w = uw(C_A0, OPND_X,  TAP_W0, OP_NONE,     ACT_NONE,   1'b0, 3'd0, '0);
         5'd10: w = uw(C_A0, OPND_X,  TAP_W0, OP_NONE,     ACT_SAT_W0, 1'b0, 3'd0, '0);
         5'd11: w = uw(C_B0, OPND_LO, TAP_W0, OP_LOAD_SHR, ACT_NONE,   1'b0, 3'd0, '0);
         5'd12: w = uw(C_B0, OPND_HI, TAP_W0, OP_ADD,      ACT_NONE,   1'b0, 3'd0, '0);
         5'd13: w = uw(C_B1, OPND_LO, TAP_W1, OP_ADD_SHR,  ACT_NONE,   1'b0, 3'd0, '0);
         5'd14: w = uw(C_B1, OPND_HI, TAP_W1, OP_ADD,      ACT_NONE,   1'b0, 3'd0, '0);
         5'd15: w = uw(C_B2, OPND_LO, TAP_W2, OP_ADD_SHR,  ACT_NONE,   1'b0, 3'd0, '0);
         5'd16: w = uw(C_B2, OPND_HI, TAP_W2, OP_ADD,      ACT_NONE,   1'b1, 3'd4,
                       STEP_FF_DRAIN);
         5'd17: w = uw(C_B3, OPND_LO, TAP_W3, OP_ADD_SHR,  ACT_NONE,   1'b0, 3'd0, '0);
         5'd18: w = uw(C_B3, OPND_HI, TAP_W3, OP_ADD,      ACT_NONE,   1'b1, 3'd5,
                       STEP_FF_DRAIN);
         5'd19: w = uw(C_B4, OPND_LO, TAP_W4, OP_ADD_SHR,  ACT_NONE,   1'b0, 3'd0, '0);
         5'd20: w = uw(C_B4, OPND_HI, TAP_W4, OP_ADD,      ACT_NONE,   1'b0, 3'd0, '0);
         5'd21: w = uw(C_A0, OPND_X,  TAP_W0, OP_NONE,     ACT_NONE,   1'b0, 3'd0, '0);
         5'd22: w = uw(C_A0, OPND_X,  TAP_W0, OP_NONE,     ACT_OUT,    1'b0, 3'd0, '0);
         default: w = uw(C_A0, OPND_X, TAP_W0, OP_NONE,    ACT_OUT,    1'b0, 3'd0, '0);
      endcase
      return w;
   endfunction

endpackage

// ===== hw/rtl/iir_direct_form_ii_filter.sv =====
// Top level of the fourth-order direct form II IIR filter with microcoded control.
//
//   Channel   Role             Payload
//   req_*     sample in        tdata[15:0] sample_in (signed)
//   rsp_*     sample out       tdata[23:0] sample_out (signed)
//   csr_*     coefficient regs 64-bit APB-style, registers at byte address 8*i
//
// No new sample beat is accepted until the program for the last one ends:
// the single shared multiplier forms two products for every tap term and one
// for the input gain, plus drain and saturation steps of the program.
// Reset is synchronous; no clearing pass is needed.
// A finished sample waits in the output register; the program stalls on its
// last step only if the previous sample has not yet been taken.
module iir_direct_form_ii_filter
   import iirdf_pkg::*;
#(
   parameter int NUM_COEFS = NUM_COEFS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // Sample in, fields from bit 0: sample_in[15:0].
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [SAMPLE_W-1:0]   req_tdata,
   // Sample out, fields from bit 0: sample_out[23:0].
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [OUT_W-1:0]      rsp_tdata,
   // Configuration port.
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int NUM_TAPS  = NUM_COEFS - 1;
   localparam int TAP_IDX_W = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;

   localparam logic signed [OUT_W-1:0] Y_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] Y_MIN = {1'b1, {(OUT_W-1){1'b0}}};
   localparam logic signed [TAP_W-1:0] W_MAX = {1'b0, {(TAP_W-1){1'b1}}};
   localparam logic signed [TAP_W-1:0] W_MIN = {1'b1, {(TAP_W-1){1'b0}}};

   logic [CSR_DATA_W-1:0]      regs_ff [NUM_REGS];
   logic [REG_IDX_W-1:0]       reg_idx;
   logic                       csr_wr;

   seq_state_type              state_ff, state_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   ucode_word_type             word;
   logic                       stall;
   logic                       req_acc;
   logic                       step_go;

   logic signed [SAMPLE_W-1:0] x_ff;
   logic signed [TAP_W-1:0]    taps_ff [NUM_TAPS];
   logic signed [TAP_W-1:0]    w0_ff;
   logic signed [TAP_W-1:0]    tap_val;
   logic [2:0]                 tap_m1;
   logic [TAP_IDX_W-1:0]       tap_idx;

   logic signed [COEF_W-1:0]   coef;
   logic signed [OPND_W-1:0]   opnd;
   mac_ctrl_type               mac_ctrl;
   logic signed [ACC_W-1:0]    acc;
   logic                       acc_fits;
   logic signed [TAP_W-1:0]    w0_sat;
   logic signed [OUT_W-1:0]    y_sat;

   logic                       rsp_valid_ff;
   logic [OUT_W-1:0]           rsp_data_ff;

   // Configuration registers: writes complete on the access beat.
   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:3];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff[REG_FF_COEF_01]  <= RST_FF_COEF_01;
         regs_ff[REG_FF_COEF_23]  <= RST_FF_COEF_23;
         regs_ff[REG_FB_COEF_01]  <= RST_FB_COEF_01;
         regs_ff[REG_FB_COEF_23]  <= RST_FB_COEF_23;
         regs_ff[REG_COEF_PAIR_4] <= RST_COEF_PAIR_4;
      end else if (csr_wr && (int'(reg_idx) < NUM_REGS)) begin
         regs_ff[reg_idx] <= csr_pwdata;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (int'(reg_idx) < NUM_REGS) begin
         csr_prdata = regs_ff[reg_idx];
      end
   end

   // Sequencer: step counter over the program with conditional jumps.
   assign word       = ucode_rom(step_ff);
   assign req_tready = (state_ff == SEQ_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign stall      = (word.act == ACT_OUT) && rsp_valid_ff && !rsp_tready;
   assign step_go    = (state_ff == SEQ_RUN) && !stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         SEQ_IDLE: begin
            step_in = '0;
            if (req_acc) begin
               state_in = SEQ_RUN;
            end
         end
         SEQ_RUN: begin
            if (!stall) begin
               if (word.act == ACT_OUT) begin
                  state_in = SEQ_IDLE;
                  step_in  = '0;
               end else if (word.jump_en && (NUM_COEFS < int'(word.jump_below))) begin
                  step_in = word.target;
               end else begin
                  step_in = step_ff + STEP_W'(1);
               end
            end
         end
         default: begin
            state_in = SEQ_IDLE;
            step_in  = '0;
         end
      endcase
   end

   // Capture the sample beat.
   always_ff @(posedge clock) begin
      if (req_acc) begin
         x_ff <= req_tdata;
      end
   end

   // Tap select; a tap beyond the filter order reads as zero.
   assign tap_m1  = word.tap_sel - 3'd1;
   assign tap_idx = tap_m1[TAP_IDX_W-1:0];

   always_comb begin
      tap_val = '0;
      if (word.tap_sel == TAP_W0) begin
         tap_val = w0_ff;
      end else if (int'(word.tap_sel) <= NUM_TAPS) begin
         tap_val = taps_ff[tap_idx];
      end
   end

   // Operand select: the sample, the low 24 bits unsigned, or the high part signed.
   always_comb begin
      case (word.opnd)
         OPND_X:  opnd = OPND_W'(x_ff);
         OPND_LO: opnd = {1'b0, tap_val[FRAC_W-1:0]};
         OPND_HI: opnd = OPND_W'($signed(tap_val[TAP_W-1:FRAC_W]));
         default: opnd = '0;
      endcase
   end

   // Coefficient select from the packed register pairs.
   always_comb begin
      case (word.coef_sel)
         C_A0:    coef = regs_ff[REG_FB_COEF_01][31:0];
         C_A1:    coef = regs_ff[REG_FB_COEF_01][63:32];
         C_A2:    coef = regs_ff[REG_FB_COEF_23][31:0];
         C_A3:    coef = regs_ff[REG_FB_COEF_23][63:32];
         C_A4:    coef = regs_ff[REG_COEF_PAIR_4][63:32];
         C_B0:    coef = regs_ff[REG_FF_COEF_01][31:0];
         C_B1:    coef = regs_ff[REG_FF_COEF_01][63:32];
         C_B2:    coef = regs_ff[REG_FF_COEF_23][31:0];
         C_B3:    coef = regs_ff[REG_FF_COEF_23][63:32];
         C_B4:    coef = regs_ff[REG_COEF_PAIR_4][31:0];
         default: coef = '0;
      endcase
   end

   assign mac_ctrl.op = step_go ? word.op : OP_NONE;

   iirdf_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .coef  (coef),
      .opnd  (opnd),
      .acc   (acc)
   );

   // Saturation: both w0 and the output fit exactly when the bits from 47 up agree.
   assign acc_fits = (acc[ACC_W-1:TAP_W-1] == {(ACC_W-TAP_W+1){1'b0}}) ||
                     (acc[ACC_W-1:TAP_W-1] == {(ACC_W-TAP_W+1){1'b1}});
   assign w0_sat   = acc_fits ? acc[TAP_W-1:0] : (acc[ACC_W-1] ? W_MIN : W_MAX);
   assign y_sat    = acc_fits ? acc[TAP_W-1:FRAC_W] : (acc[ACC_W-1] ? Y_MIN : Y_MAX);

   // New delay value at the saturation step, and the delay line shift at the end of the sample.
   always_ff @(posedge clock) begin
      if (step_go && (word.act == ACT_SAT_W0)) begin
         w0_ff <= w0_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TAPS; i++) begin
            taps_ff[i] <= '0;
         end
      end else if (step_go && (word.act == ACT_OUT)) begin
         for (int i = NUM_TAPS - 1; i > 0; i--) begin
            taps_ff[i] <= taps_ff[i-1];
         end
         taps_ff[0] <= w0_ff;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_go && (word.act == ACT_OUT)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_go && (word.act == ACT_OUT)) begin
         rsp_data_ff <= y_sat;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // An accepted beat starts the program at its first step.
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff == SEQ_RUN) && (step_ff == '0))
      else $error("program did not start after a sample beat");

   // The step counter stays inside the program.
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_RUN) |-> (step_ff <= STEP_LAST))
      else $error("step counter ran past the program");

   // Completing the last step always presents a result.
   a_result: assert property (@(posedge clock) disable iff (reset)
      (step_go && (word.act == ACT_OUT)) |=> rsp_tvalid)
      else $error("finished sample was not presented");

   // An in-range feedback sum passes into w0 unchanged.
   a_w0_exact: assert property (@(posedge clock) disable iff (reset)
      (step_go && (word.act == ACT_SAT_W0) && acc_fits) |=> (w0_ff == $past(acc[TAP_W-1:0])))
      else $error("w0 differs from an in-range feedback sum");

   // The last step waits while the previous result is still held.
   a_stall: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == SEQ_RUN) && stall) |=> ((state_ff == SEQ_RUN) && $stable(step_ff)))
      else $error("program moved on while the output was blocked");

endmodule

// ===== hw/rtl/iirdf_mac.sv =====
// Shared multiply-accumulate unit: one registered 32x25 product and a wide accumulator.
module iirdf_mac
   import iirdf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  mac_ctrl_type             ctrl,
   input  logic signed [COEF_W-1:0] coef,
   input  logic signed [OPND_W-1:0] opnd,
   output logic signed [ACC_W-1:0]  acc
);

   logic signed [PROD_W-1:0] coef_ext;
   logic signed [PROD_W-1:0] opnd_ext;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   acc_op_type               op_ff;
   logic signed [ACC_W-1:0]  prod_full;
   logic signed [ACC_W-1:0]  prod_shr;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  acc_ff;

   // Multiply stage: the operation travels with its product.
   assign coef_ext = PROD_W'(coef);
   assign opnd_ext = PROD_W'(opnd);
   assign prod_in  = coef_ext * opnd_ext;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         op_ff <= OP_NONE;
      end else begin
         op_ff <= ctrl.op;
      end
   end

   // The arithmetic shift floors the product to whole Q.24 units.
   assign prod_full = ACC_W'(prod_ff);
   assign prod_shr  = ACC_W'(prod_ff >>> FRAC_W);

   // Accumulate stage.
   always_comb begin
      case (op_ff)
         OP_NONE:     acc_in = acc_ff;
         OP_LOAD:     acc_in = prod_full;
         OP_LOAD_SHR: acc_in = prod_shr;
         OP_ADD:      acc_in = acc_ff + prod_full;
         OP_ADD_SHR:  acc_in = acc_ff + prod_shr;
         OP_SUB:      acc_in = acc_ff - prod_full;
         OP_SUB_SHR:  acc_in = acc_ff - prod_shr;
         default:     acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ===== tb/iir_sample_checker.sv =====
// Watches the channels, checks register reads, predicts each output sample and compares it.
module iir_sample_checker
   import iirdf_pkg::*;
#(
   parameter int NUM_COEFS = NUM_COEFS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // Sample in, fields from bit 0: sample_in[15:0].
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [SAMPLE_W-1:0]   req_tdata,
   // Sample out, fields from bit 0: sample_out[23:0].
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [OUT_W-1:0]      rsp_tdata,
   // Configuration port.
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   input  logic                  csr_pready,
   output int                    mismatch_count,
   output int                    outstanding
);

   localparam longint TAP_MAX = (longint'(1) <<< (TAP_W - 1)) - 1;
   localparam longint TAP_MIN = -TAP_MAX - 1;
   localparam longint OUT_MAX = (longint'(1) <<< (OUT_W - 1)) - 1;
   localparam longint OUT_MIN = -OUT_MAX - 1;

   // Shadow copy of the coefficient registers and of the delay line w1..w4.
   logic [CSR_DATA_W-1:0] coef_regs [NUM_REGS];
   longint                delay_line [MAX_TAPS];
   logic [OUT_W-1:0]      expected_samples [$];
   int                    mismatches = 0;

   assign mismatch_count = mismatches;

   // Prints one line per discrepancy and counts it.
   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   // Signed Q8.24 coefficient from one half of a register.
   function automatic longint coef_half(input logic [CSR_DATA_W-1:0] value, input bit upper);
      return upper ? longint'($signed(value[63:32])) : longint'($signed(value[31:0]));
   endfunction

   function automatic longint clamp_range(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Coefficient times delay value, floored to Q.24. The tap is split into its
   // fraction and its integer part so that no intermediate overflows 64 bits.
   function automatic longint mul_floor_q24(input longint coef, input longint tap);
      longint tap_int;
      longint tap_frac;
      tap_int  = tap >>> FRAC_W;
      tap_frac = tap - (tap_int <<< FRAC_W);
      return coef * tap_int + ((coef * tap_frac) >>> FRAC_W);
   endfunction

   // Runs one sample through the filter and advances the delay line.
   task automatic predict_sample(input logic [SAMPLE_W-1:0] raw_in,
                                 output logic [OUT_W-1:0] predicted);
      longint ff [MAX_TAPS+1];
      longint fb [MAX_TAPS+1];
      longint acc;
      longint w0;
      longint y;
      ff[0] = coef_half(coef_regs[REG_FF_COEF_01], 1'b0);
      ff[1] = coef_half(coef_regs[REG_FF_COEF_01], 1'b1);
      ff[2] = coef_half(coef_regs[REG_FF_COEF_23], 1'b0);
      ff[3] = coef_half(coef_regs[REG_FF_COEF_23], 1'b1);
      ff[4] = coef_half(coef_regs[REG_COEF_PAIR_4], 1'b0);
      fb[0] = coef_half(coef_regs[REG_FB_COEF_01], 1'b0);
      fb[1] = coef_half(coef_regs[REG_FB_COEF_01], 1'b1);
      fb[2] = coef_half(coef_regs[REG_FB_COEF_23], 1'b0);
      fb[3] = coef_half(coef_regs[REG_FB_COEF_23], 1'b1);
      fb[4] = coef_half(coef_regs[REG_COEF_PAIR_4], 1'b1);

      // Feedback half: the gain term is exact, every tap term is floored.
      acc = fb[0] * longint'($signed(raw_in));
      for (int k = 1; k < NUM_COEFS && k <= MAX_TAPS; k++)
         acc -= mul_floor_q24(fb[k], delay_line[k-1]);
      w0 = clamp_range(acc, TAP_MIN, TAP_MAX);

      // Feedforward half, then floor to an integer and saturate.
      acc = mul_floor_q24(ff[0], w0);
      for (int k = 1; k < NUM_COEFS && k <= MAX_TAPS; k++)
         acc += mul_floor_q24(ff[k], delay_line[k-1]);
      y = clamp_range(acc >>> FRAC_W, OUT_MIN, OUT_MAX);

      for (int k = MAX_TAPS - 1; k > 0; k--)
         delay_line[k] = delay_line[k-1];
      delay_line[0] = w0;
      predicted = y[OUT_W-1:0];
   endtask

   // Register traffic, sample beats in and sample beats out, in that order.
   always @(posedge clock) begin : watch
      logic [OUT_W-1:0]     predicted;
      logic [OUT_W-1:0]     oldest;
      logic [REG_IDX_W-1:0] reg_idx;
      reg_idx = csr_paddr[CSR_ADDR_W-1:3];
      if (reset) begin
         coef_regs[REG_FF_COEF_01]  = RST_FF_COEF_01;
         coef_regs[REG_FF_COEF_23]  = RST_FF_COEF_23;
         coef_regs[REG_FB_COEF_01]  = RST_FB_COEF_01;
         coef_regs[REG_FB_COEF_23]  = RST_FB_COEF_23;
         coef_regs[REG_COEF_PAIR_4] = RST_COEF_PAIR_4;
         foreach (delay_line[k]) delay_line[k] = 0;
         expected_samples.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready && int'(reg_idx) < NUM_REGS) begin
            if (csr_pwrite) begin
               coef_regs[reg_idx] = csr_pwdata;
            end else if (csr_prdata !== coef_regs[reg_idx]) begin
               report_mismatch($sformatf("register %0d read %h, expected %h",
                                         reg_idx, csr_prdata, coef_regs[reg_idx]));
            end
         end
         if (req_tvalid && req_tready) begin
            predict_sample(req_tdata, predicted);
            expected_samples.push_back(predicted);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_samples.size() == 0) begin
               report_mismatch($sformatf("output beat %h with no sample outstanding",
                                         rsp_tdata));
            end else begin
               oldest = expected_samples.pop_front();
               if (rsp_tdata !== oldest)
                  report_mismatch($sformatf("sample_out %0d, expected %0d",
                                            $signed(rsp_tdata), $signed(oldest)));
            end
         end
      end
      outstanding <= expected_samples.size();
   end

endmodule

// ===== tb/iir_direct_form_ii_filter_tb.sv =====
// Drives samples and coefficient settings into the IIR filter and gives the verdict.
module iir_direct_form_ii_filter_tb;
   import iirdf_pkg::*;

   localparam int ITEMS_PER_PHASE = 75;
   localparam int RANDOM_PHASES   = 6;
   localparam int LONG_HOLD       = 300;
   localparam int SETTLE_CYCLES   = 48;
   localparam int DRAIN_LIMIT     = 4000;

   typedef enum {COEF_DAMPED, COEF_UNIT, COEF_FULL} coef_kind_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [SAMPLE_W-1:0]   req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [OUT_W-1:0]      rsp_tdata;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    mismatch_count;
   int                    outstanding;
   bit                    hold_off = 1'b0;
   int                    req_burst = 0;
   int                    rsp_burst = 0;

   always #4 clock = ~clock;

   iir_direct_form_ii_filter #(.NUM_COEFS(NUM_COEFS_DEF)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   iir_sample_checker #(.NUM_COEFS(NUM_COEFS_DEF)) sample_monitor (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // Idle cycles before the next beat; now and then a burst with no idling at all.
   function automatic int draw_gap(inout int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 7) == 0) begin
         burst_left = $urandom_range(8, 24);
         return 0;
      end
      return $urandom_range(0, 16);
   endfunction

   // Random Q8.24 coefficient; damped feedback keeps the filter mostly stable.
   function automatic logic [COEF_W-1:0] rand_coef(input coef_kind_type kind, input bit feedback);
      int span;
      case (kind)
         COEF_FULL: return $urandom;
         COEF_UNIT: span = 1 << FRAC_W;
         default:   span = feedback ? (1 << (FRAC_W - 2)) : (1 << FRAC_W);
      endcase
      return COEF_W'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   // One APB write: setup cycle, access cycle, then release the bus.
   task automatic csr_write(input int idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx << 3);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // One APB read; the checker compares the returned value.
   task automatic csr_read(input int idx);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(idx << 3);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_all_regs();
      for (int idx = 0; idx < NUM_REGS; idx++) csr_read(idx);
   endtask

   // Waits until every predicted sample has come back.
   task automatic wait_drained();
      while (outstanding != 0) @(posedge clock);
   endtask

   // Offers a run of sample beats with random gaps; valid stays high across
   // back-to-back beats and drops after the last one.
   task automatic feed_samples(input logic [SAMPLE_W-1:0] batch [$]);
      int gap;
      foreach (batch[i]) begin
         gap = draw_gap(req_burst);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            req_tdata  <= SAMPLE_W'($urandom);
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= batch[i];
         @(posedge clock);
         while (!req_tready) @(posedge clock);
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // Result side: random back-pressure, plus one long hold when asked.
   initial begin : receiver
      int gap;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off) begin
            hold_off = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         gap = draw_gap(rsp_burst);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // Hard stop in case the DUT hangs.
   initial begin : watchdog
      #2400000;
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      logic [SAMPLE_W-1:0] batch [$];
      coef_kind_type       kind;
      int                  drain;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset coefficients pass the sample straight through.
      read_all_regs();
      batch = '{16'sd32767, -16'sd32768, 16'sd0, -16'sd1, 16'sd1, 16'h5555, 16'hAAAA};
      feed_samples(batch);

      // Largest gains with the most negative feedback: the delay values and
      // the output both run into saturation.
      wait_drained();
      csr_write(REG_FF_COEF_01,  {32'h7FFF_FFFF, 32'h7FFF_FFFF});
      csr_write(REG_FF_COEF_23,  {32'h7FFF_FFFF, 32'h7FFF_FFFF});
      csr_write(REG_FB_COEF_01,  {32'h8000_0000, 32'h7FFF_FFFF});
      csr_write(REG_FB_COEF_23,  {32'h8000_0000, 32'h8000_0000});
      csr_write(REG_COEF_PAIR_4, {32'h8000_0000, 32'h7FFF_FFFF});
      read_all_regs();
      batch = '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768};
      feed_samples(batch);

      // Writes outside the register map must leave the coefficients alone.
      wait_drained();
      for (int idx = NUM_REGS; idx < (1 << REG_IDX_W); idx++)
         csr_write(idx, {$urandom, $urandom});
      read_all_regs();

      // Most negative coefficients everywhere.
      csr_write(REG_FF_COEF_01,  {32'h8000_0000, 32'h8000_0000});
      csr_write(REG_FF_COEF_23,  {32'h8000_0000, 32'h8000_0000});
      csr_write(REG_FB_COEF_01,  {32'h8000_0000, 32'h8000_0000});
      csr_write(REG_FB_COEF_23,  {32'h8000_0000, 32'h8000_0000});
      csr_write(REG_COEF_PAIR_4, {32'h8000_0000, 32'h8000_0000});
      batch = '{16'sd32767, -16'sd32768, -16'sd32768, -16'sd32768, 16'sd0, 16'sd32767};
      feed_samples(batch);

      // Random phases, each with a fresh coefficient set.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       kind = COEF_DAMPED;
            1:       kind = COEF_UNIT;
            2:       kind = COEF_FULL;
            default: kind = coef_kind_type'($urandom_range(0, 2));
         endcase
         wait_drained();
         csr_write(REG_FF_COEF_01,  {rand_coef(kind, 1'b0), rand_coef(kind, 1'b0)});
         csr_write(REG_FF_COEF_23,  {rand_coef(kind, 1'b0), rand_coef(kind, 1'b0)});
         csr_write(REG_FB_COEF_01,  {rand_coef(kind, 1'b1), rand_coef(kind, 1'b0)});
         csr_write(REG_FB_COEF_23,  {rand_coef(kind, 1'b1), rand_coef(kind, 1'b1)});
         csr_write(REG_COEF_PAIR_4, {rand_coef(kind, 1'b1), rand_coef(kind, 1'b0)});
         read_all_regs();
         batch.delete();
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            case ($urandom_range(0, 9))
               0:       batch.push_back(16'sd32767);
               1:       batch.push_back(-16'sd32768);
               default: batch.push_back(SAMPLE_W'($urandom));
            endcase
         end
         // Hold the output off for a long stretch so that the input backs up.
         if (phase == 0) hold_off = 1'b1;
         feed_samples(batch);
      end

      // Drain, then let the pipeline settle before the verdict.
      for (drain = 0; drain < DRAIN_LIMIT && outstanding != 0; drain++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/iirdf_pkg.sv
hw/rtl/iirdf_mac.sv
hw/rtl/iir_direct_form_ii_filter.sv
tb/iir_sample_checker.sv
tb/iir_direct_form_ii_filter_tb.sv
